### rtl/eyerem_pkg.sv
// Shared constants and types for the eye-motion REM detector.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package eyerem_pkg;

    typedef logic [31:0] ms_t;
    typedef logic [7:0]  count_t;
    typedef logic [8:0]  toggle_t;

    // Button actions carried in tuser.
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_SNOOZE  = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SENSITIVITY  = 3'd0;
    localparam logic [2:0] REG_TRIGGER      = 3'd1;
    localparam logic [2:0] REG_DECAY_PERIOD = 3'd2;
    localparam logic [2:0] REG_INIT_DELAY   = 3'd3;
    localparam logic [2:0] REG_SNOOZE       = 3'd4;
    localparam logic [2:0] REG_POST_DELAY   = 3'd5;
    localparam logic [2:0] REG_SIGNAL_COUNT = 3'd6;
    localparam logic [2:0] REG_SIGNAL_LEN   = 3'd7;

    localparam int CFG_DATA_W = 22;

    // Register values after reset.
    localparam logic [11:0] RST_SENSITIVITY  = 12'd45;
    localparam logic [5:0]  RST_TRIGGER      = 6'd5;
    localparam logic [15:0] RST_DECAY_PERIOD = 16'd12000;
    localparam logic [21:0] RST_INIT_DELAY   = 22'd12000;
    localparam logic [21:0] RST_SNOOZE       = 22'd6000;
    localparam logic [21:0] RST_POST_DELAY   = 22'd300000;
    localparam logic [7:0]  RST_SIGNAL_COUNT = 8'd20;
    localparam logic [15:0] RST_SIGNAL_LEN   = 16'd500;

    localparam ms_t     RST_DETECT_START = 32'd12000;
    localparam ms_t     RETRY_MS         = 32'd100;
    localparam toggle_t TOGGLE_MAX       = 9'd511;
    localparam count_t  COUNT_MAX        = 8'd255;

    // Floor of x/3 for 12-bit x: x * 2731 >> 13 is exact over the whole range.
    localparam logic [11:0] DIV3_RECIP = 12'd2731;
    localparam int          DIV3_SHIFT = 13;

endpackage

`default_nettype wire

### rtl/eye_motion_rem_detector_top.sv
// Top level of the eye-motion REM detector with light alert.
// Depends on eyerem_pkg for constants, register indexes and action codes.
//
//  Channel | Signals                              | Item
//  --------+--------------------------------------+------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser    | one 1 ms tick: action and two samples
//  out     | m_tvalid m_tready m_tdata            | LED, alert flag, counts, beep
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | one register write
//
// An item waits in the input register and is then evaluated against the state
// registers in one pass into the output register. One item per cycle is sustained
// while m_tready holds. The input register advances whenever the output register is
// empty or being taken, so an item is accepted while a result still waits.
// Reset clears the pipeline valids, restores the register defaults and sets the
// time base and detection state to their initial values. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module eye_motion_rem_detector_top
    import eyerem_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [SAMPLE_BITS-1:0] left_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_sample
    input  wire logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // [1:0] action
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] led_on, [1] alert_active, [9:2] left_movements,
    // [17:10] right_movements, [18] baseline_beep
    output logic [((19 + 7) / 8) * 8 - 1:0] m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IN_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 19;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CMP_W      = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // Configuration registers.
    logic [11:0] sensitivity_reg;
    logic [5:0]  trigger_reg;
    logic [15:0] decay_period_reg;
    logic [21:0] init_delay_reg;
    logic [21:0] snooze_reg;
    logic [21:0] post_delay_reg;
    logic [7:0]  signal_count_reg;
    logic [15:0] signal_len_reg;

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  in_action_reg;
    sample_t     in_smp_reg [2];

    // Output register.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    // Detector state.
    ms_t     now_reg, now_next;
    ms_t     detect_start_reg, detect_start_next;
    ms_t     last_decay_reg, last_decay_next;
    sample_t baseline_reg [2];
    sample_t baseline_next [2];
    count_t  count_reg [2];
    count_t  count_next [2];
    logic    alert_reg, alert_next;
    toggle_t toggles_reg, toggles_next;
    ms_t     next_toggle_reg, next_toggle_next;
    logic    led_reg, led_next;

    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensitivity_reg  <= RST_SENSITIVITY;
            trigger_reg      <= RST_TRIGGER;
            decay_period_reg <= RST_DECAY_PERIOD;
            init_delay_reg   <= RST_INIT_DELAY;
            snooze_reg       <= RST_SNOOZE;
            post_delay_reg   <= RST_POST_DELAY;
            signal_count_reg <= RST_SIGNAL_COUNT;
            signal_len_reg   <= RST_SIGNAL_LEN;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SENSITIVITY:  sensitivity_reg  <= cfg_data[11:0];
                REG_TRIGGER:      trigger_reg      <= cfg_data[5:0];
                REG_DECAY_PERIOD: decay_period_reg <= cfg_data[15:0];
                REG_INIT_DELAY:   init_delay_reg   <= cfg_data;
                REG_SNOOZE:       snooze_reg       <= cfg_data;
                REG_POST_DELAY:   post_delay_reg   <= cfg_data;
                REG_SIGNAL_COUNT: signal_count_reg <= cfg_data[7:0];
                REG_SIGNAL_LEN:   signal_len_reg   <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------- input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg <= s_tuser;
            in_smp_reg[0] <= s_tdata[SAMPLE_BITS-1:0];
            in_smp_reg[1] <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
    end

    // ------------------------------------------------------ evaluation pass
    logic [23:0]      sens_prod;
    logic [CMP_W-1:0] sens_div3;
    logic [CMP_W-1:0] sens_w;

    assign sens_prod = sensitivity_reg * DIV3_RECIP;
    assign sens_div3 = CMP_W'(sens_prod[23:DIV3_SHIFT]);
    assign sens_w    = CMP_W'(sensitivity_reg);

    function automatic sample_t abs_diff(input sample_t a, input sample_t b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        ms_t              t;
        ms_t              ds0;
        logic             alert0, led0, led1, beep;
        sample_t          bl0 [2];
        count_t           cnt1 [2];
        sample_t          dev_l, dev_r, dev_max, dev;
        logic             decay_hit, detect, trig, tog;
        ms_t              decay_due, decay_late;
        toggle_t          td1;

        t                = now_reg;
        now_next         = t + 32'd1;
        ds0              = detect_start_reg;
        alert0           = alert_reg;
        led0             = led_reg;
        beep             = 1'b0;
        bl0[0]           = baseline_reg[0];
        bl0[1]           = baseline_reg[1];
        dev_l            = abs_diff(in_smp_reg[0], baseline_reg[0]);
        dev_r            = abs_diff(in_smp_reg[1], baseline_reg[1]);
        dev_max          = (dev_l >= dev_r) ? dev_l : dev_r;

        // Button action.
        if (in_action_reg == ACT_RESTART)
        begin
            alert0 = 1'b0;
            led0   = 1'b0;
            ds0    = t + ms_t'(init_delay_reg);
            if (CMP_W'(dev_max) >= sens_div3)
            begin
                bl0[0] = in_smp_reg[0];
                bl0[1] = in_smp_reg[1];
                beep   = 1'b1;
            end
        end
        else if (in_action_reg == ACT_SNOOZE)
        begin
            alert0 = 1'b0;
            led0   = 1'b0;
            ds0    = (detect_start_reg > t) ? (detect_start_reg + ms_t'(snooze_reg))
                                            : (t + ms_t'(snooze_reg));
        end

        // Leaky decay of the counts.
        decay_due  = last_decay_reg + ms_t'(decay_period_reg);
        decay_late = last_decay_reg + ms_t'({decay_period_reg, 1'b0});
        decay_hit  = (decay_due <= t);
        last_decay_next = last_decay_reg;
        for (int e = 0; e < 2; e++)
        begin
            cnt1[e] = (decay_hit && count_reg[e] != '0) ? count_reg[e] - 8'd1 : count_reg[e];
        end
        if (decay_hit)
        begin
            last_decay_next = (decay_late < t) ? t : decay_due;
        end

        // Movement detection.
        detect            = (ds0 <= t);
        detect_start_next = ds0;
        alert_next        = alert0;
        for (int e = 0; e < 2; e++)
        begin
            baseline_next[e] = bl0[e];
            count_next[e]    = cnt1[e];
            dev              = abs_diff(in_smp_reg[e], bl0[e]);
            if (detect && CMP_W'(dev) >= sens_w)
            begin
                count_next[e]    = (cnt1[e] != COUNT_MAX) ? cnt1[e] + 8'd1 : cnt1[e];
                baseline_next[e] = in_smp_reg[e];
            end
        end
        trig = (count_next[0] >= 8'(trigger_reg)) || (count_next[1] >= 8'(trigger_reg));
        if (detect)
        begin
            if (trig)
            begin
                detect_start_next = t + ms_t'(post_delay_reg);
                alert_next        = 1'b1;
            end
            else
            begin
                detect_start_next = t + RETRY_MS;
            end
        end

        // LED alert sequence.
        led_next         = led0;
        toggles_next     = toggles_reg;
        next_toggle_next = next_toggle_reg;
        tog  = (next_toggle_reg <= t);
        led1 = tog ? !led0 : led0;
        td1  = (tog && toggles_reg != TOGGLE_MAX) ? toggles_reg + 9'd1 : toggles_reg;
        if (alert_next)
        begin
            if (tog)
            begin
                next_toggle_next = t + ms_t'(signal_len_reg);
            end
            toggles_next = td1;
            led_next     = led1;
            if (td1 >= {signal_count_reg, 1'b0})
            begin
                led_next   = 1'b0;
                alert_next = 1'b0;
            end
        end
        else
        begin
            toggles_next = '0;
        end

        out_data_next = OUT_DATA_W'({beep, count_next[1], count_next[0], alert_next,
                                     led_next});
    end

    // ------------------------------------------------- state and result regs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg          <= '0;
            detect_start_reg <= RST_DETECT_START;
            last_decay_reg   <= '0;
            baseline_reg[0]  <= '0;
            baseline_reg[1]  <= '0;
            count_reg[0]     <= '0;
            count_reg[1]     <= '0;
            alert_reg        <= 1'b0;
            toggles_reg      <= '0;
            next_toggle_reg  <= '0;
            led_reg          <= 1'b0;
        end
        else if (advance)
        begin
            now_reg          <= now_next;
            detect_start_reg <= detect_start_next;
            last_decay_reg   <= last_decay_next;
            baseline_reg[0]  <= baseline_next[0];
            baseline_reg[1]  <= baseline_next[1];
            count_reg[0]     <= count_next[0];
            count_reg[1]     <= count_next[1];
            alert_reg        <= alert_next;
            toggles_reg      <= toggles_next;
            next_toggle_reg  <= next_toggle_next;
            led_reg          <= led_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // The LED is only ever lit while an alert sequence runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("LED lit without a running alert");

    // The time base moves by exactly one millisecond per evaluated item.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> now_reg == $past(now_reg) + 32'd1)
        else $error("time base did not advance by one");

    // A baseline beep can only come from a restart item.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_action_reg != ACT_RESTART |=> !m_tdata[18])
        else $error("baseline beep without restart");

    // A held input register keeps its item until the result side frees up.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_action_reg))
        else $error("pending item lost from the input register");
`endif

endmodule

`default_nettype wire

### sim/eyerem_tick_checker.sv
// Checker for the eye-motion REM detector: watches the tick, result and register channels,
// tracks its own copy of the detector state and compares each result with its prediction.
// Depends on eyerem_pkg for action codes, register indexes, reset values and limits.
`timescale 1ns / 1ps

module eyerem_tick_checker
    import eyerem_pkg::*;
#(
    parameter int IN_W  = 24,
    parameter int OUT_W = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_W-1:0]       s_tdata,
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_W-1:0]      m_tdata,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         outstanding,
    output int                         results_seen,
    output int                         alert_ticks,
    output int                         baseline_captures
);

    // Field order matches m_tdata from bit 18 down to bit 0.
    typedef struct packed {
        logic   beep;
        count_t right_cnt;
        count_t left_cnt;
        logic   alert;
        logic   led;
    } tick_out_t;

    logic [11:0] sens;
    logic [5:0]  trig;
    logic [15:0] decay_period;
    logic [21:0] init_delay;
    logic [21:0] snooze_len;
    logic [21:0] post_delay;
    logic [7:0]  sig_count;
    logic [15:0] sig_len;

    ms_t         clock_ms;
    ms_t         window_ms;
    ms_t         decay_mark_ms;
    ms_t         toggle_due_ms;
    logic [11:0] base [2];
    count_t      moves [2];
    logic        alarm;
    logic        led;
    toggle_t     toggles;

    tick_out_t   expected_ticks [$];
    int          mismatches;
    int          checked;
    int          alerts;
    int          beeps;

    function automatic logic [11:0] sample_gap(input logic [11:0] a, input logic [11:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function void restore_defaults();
        sens          = RST_SENSITIVITY;
        trig          = RST_TRIGGER;
        decay_period  = RST_DECAY_PERIOD;
        init_delay    = RST_INIT_DELAY;
        snooze_len    = RST_SNOOZE;
        post_delay    = RST_POST_DELAY;
        sig_count     = RST_SIGNAL_COUNT;
        sig_len       = RST_SIGNAL_LEN;
        clock_ms      = '0;
        window_ms     = RST_DETECT_START;
        decay_mark_ms = '0;
        toggle_due_ms = '0;
        base[0]       = '0;
        base[1]       = '0;
        moves[0]      = '0;
        moves[1]      = '0;
        alarm         = 1'b0;
        led           = 1'b0;
        toggles       = '0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_SENSITIVITY:  sens         = val[11:0];
            REG_TRIGGER:      trig         = val[5:0];
            REG_DECAY_PERIOD: decay_period = val[15:0];
            REG_INIT_DELAY:   init_delay   = val[21:0];
            REG_SNOOZE:       snooze_len   = val[21:0];
            REG_POST_DELAY:   post_delay   = val[21:0];
            REG_SIGNAL_COUNT: sig_count    = val[7:0];
            REG_SIGNAL_LEN:   sig_len      = val[15:0];
            default: ;
        endcase
    endfunction

    // One millisecond of detector behavior: action, decay, detection, then the LED alert.
    function automatic tick_out_t advance_one_ms(input logic [1:0] act,
                                                 input logic [11:0] left_smp,
                                                 input logic [11:0] right_smp);
        logic [11:0] smp [2];
        logic [11:0] dl;
        logic [11:0] dr;
        tick_out_t   r;
        int          e;
        smp[0] = left_smp;
        smp[1] = right_smp;
        r = '0;
        if (act == ACT_RESTART) begin
            dl = sample_gap(left_smp, base[0]);
            dr = sample_gap(right_smp, base[1]);
            alarm = 1'b0;
            led = 1'b0;
            window_ms = clock_ms + ms_t'(init_delay);
            if (((dl >= dr) ? dl : dr) >= sens / 3) begin
                base[0] = left_smp;
                base[1] = right_smp;
                r.beep = 1'b1;
            end
        end
        else if (act == ACT_SNOOZE) begin
            alarm = 1'b0;
            if (window_ms > clock_ms)
                window_ms = window_ms + ms_t'(snooze_len);
            else
                window_ms = clock_ms + ms_t'(snooze_len);
            led = 1'b0;
        end

        if (ms_t'(decay_mark_ms + ms_t'(decay_period)) <= clock_ms) begin
            for (e = 0; e < 2; e++)
                if (moves[e] != '0)
                    moves[e] = moves[e] - 1'b1;
            // A mark that lags by more than two periods is pulled up to now.
            if (ms_t'(decay_mark_ms + (ms_t'(decay_period) << 1)) < clock_ms)
                decay_mark_ms = clock_ms;
            else
                decay_mark_ms = decay_mark_ms + ms_t'(decay_period);
        end

        if (window_ms <= clock_ms) begin
            for (e = 0; e < 2; e++) begin
                if (sample_gap(smp[e], base[e]) >= sens) begin
                    if (moves[e] != COUNT_MAX)
                        moves[e] = moves[e] + 1'b1;
                    base[e] = smp[e];
                end
            end
            if (moves[0] >= trig || moves[1] >= trig) begin
                window_ms = clock_ms + ms_t'(post_delay);
                alarm = 1'b1;
            end
            else begin
                window_ms = clock_ms + RETRY_MS;
            end
        end

        if (alarm) begin
            if (toggle_due_ms <= clock_ms) begin
                led = !led;
                if (toggles != TOGGLE_MAX)
                    toggles = toggles + 1'b1;
                toggle_due_ms = clock_ms + ms_t'(sig_len);
            end
            if (ms_t'(toggles) >= (ms_t'(sig_count) << 1)) begin
                led = 1'b0;
                alarm = 1'b0;
            end
        end
        else begin
            toggles = '0;
        end

        r.led = led;
        r.alert = alarm;
        r.left_cnt = moves[0];
        r.right_cnt = moves[1];
        clock_ms = clock_ms + 1;
        return r;
    endfunction

    function void flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     checked, field, want, got);
    endfunction

    function void check_result(input logic [OUT_W-1:0] data);
        tick_out_t got;
        tick_out_t want;
        got = data[18:0];
        if (expected_ticks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d arrived with no tick outstanding: %h", checked, data);
        end
        else begin
            want = expected_ticks.pop_front();
            if (got.led !== want.led)
                flag_field("led_on", 8'(want.led), 8'(got.led));
            if (got.alert !== want.alert)
                flag_field("alert_active", 8'(want.alert), 8'(got.alert));
            if (got.left_cnt !== want.left_cnt)
                flag_field("left_movements", want.left_cnt, got.left_cnt);
            if (got.right_cnt !== want.right_cnt)
                flag_field("right_movements", want.right_cnt, got.right_cnt);
            if (got.beep !== want.beep)
                flag_field("baseline_beep", 8'(want.beep), 8'(got.beep));
            if (want.alert)
                alerts++;
            if (want.beep)
                beeps++;
        end
        checked++;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            restore_defaults();
            expected_ticks.delete();
            mismatches = 0;
            checked = 0;
            alerts = 0;
            beeps = 0;
        end
        else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (cfg_valid && cfg_ready)
                write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                expected_ticks.push_back(advance_one_ms(s_tuser, s_tdata[11:0], s_tdata[23:12]));
        end
        fail_count        <= mismatches;
        outstanding       <= expected_ticks.size();
        results_seen      <= checked;
        alert_ticks       <= alerts;
        baseline_captures <= beeps;
    end

endmodule

### sim/tb_eye_motion_rem_detector_top.sv
// Testbench top for the eye-motion REM detector: clock, reset, tick stimulus, register
// settings and the verdict. Depends on eyerem_pkg, the detector top and eyerem_tick_checker.
`timescale 1ns / 1ps

module tb_eye_motion_rem_detector_top;
    import eyerem_pkg::*;

    localparam int IN_W        = 24;
    localparam int OUT_W       = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 7;
    localparam int PHASE_TICKS = 182;

    // Action code 3 has no function; the detector treats it as a plain tick.
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam int CFG_RANDOM = 0;
    localparam int CFG_FLOOR  = 1;
    localparam int CFG_CEIL   = 2;

    localparam logic [2:0] REG_ORDER [8] = '{REG_SENSITIVITY, REG_TRIGGER, REG_DECAY_PERIOD,
                                             REG_INIT_DELAY, REG_SNOOZE, REG_POST_DELAY,
                                             REG_SIGNAL_COUNT, REG_SIGNAL_LEN};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_W-1:0]       s_tdata = '0;
    logic [1:0]            s_tuser = ACT_TICK;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [2:0]            cfg_index = REG_SENSITIVITY;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire                   cfg_ready;
    wire [OUT_W-1:0]       m_tdata;

    int fail_count;
    int outstanding;
    int results_seen;
    int alert_ticks;
    int baseline_captures;

    int          cycles = 0;
    int          stall_mode = 0;
    int          burst_left = 0;
    int          ticks_sent = 0;
    int          settings = 0;
    logic        gaps_on = 1'b0;
    logic [11:0] left_level = '0;
    logic [11:0] right_level = '0;
    logic [CFG_DATA_W-1:0] reg_vals [8];

    eye_motion_rem_detector_top #(
        .SAMPLE_BITS (12)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    eyerem_tick_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .outstanding       (outstanding),
        .results_seen      (results_seen),
        .alert_ticks       (alert_ticks),
        .baseline_captures (baseline_captures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycles, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    // The result side never stalls, stalls at random, or follows a fixed duty pattern.
    always @(posedge clk)
    begin
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 99) >= 35);
            default: m_tready <= ((cycles % 7) >= 3);
        endcase
    end

    task automatic push_tick(input logic [1:0] act, input logic [11:0] ls, input logic [11:0] rs);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {rs, ls};
        do @(posedge clk); while (!s_tready);
        ticks_sent++;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(0, 30);
            end
            else
                burst_left--;
        end
    endtask

    // Let every outstanding result drain before touching the registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs();
        int i;
        for (i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data  <= reg_vals[REG_ORDER[i]];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic pick_config(input int flavor);
        case (flavor)
            CFG_FLOOR:
            begin
                reg_vals[REG_SENSITIVITY]  = '0;
                reg_vals[REG_TRIGGER]      = '0;
                reg_vals[REG_DECAY_PERIOD] = '0;
                reg_vals[REG_INIT_DELAY]   = '0;
                reg_vals[REG_SNOOZE]       = '0;
                reg_vals[REG_POST_DELAY]   = '0;
                reg_vals[REG_SIGNAL_COUNT] = '0;
                reg_vals[REG_SIGNAL_LEN]   = '0;
            end
            CFG_CEIL:
            begin
                reg_vals[REG_SENSITIVITY]  = 22'd4095;
                reg_vals[REG_TRIGGER]      = 22'd63;
                reg_vals[REG_DECAY_PERIOD] = 22'd65535;
                reg_vals[REG_INIT_DELAY]   = 22'h3FFFFF;
                reg_vals[REG_SNOOZE]       = 22'h3FFFFF;
                reg_vals[REG_POST_DELAY]   = 22'h3FFFFF;
                reg_vals[REG_SIGNAL_COUNT] = 22'd255;
                reg_vals[REG_SIGNAL_LEN]   = 22'd65535;
            end
            default:
            begin
                reg_vals[REG_SENSITIVITY]  = CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                                             $urandom_range(0, 4095) : $urandom_range(1, 300));
                reg_vals[REG_TRIGGER]      = CFG_DATA_W'($urandom_range(0, 6));
                reg_vals[REG_DECAY_PERIOD] = CFG_DATA_W'($urandom_range(0, 400));
                reg_vals[REG_INIT_DELAY]   = CFG_DATA_W'($urandom_range(0, 150));
                reg_vals[REG_SNOOZE]       = CFG_DATA_W'($urandom_range(0, 200));
                reg_vals[REG_POST_DELAY]   = CFG_DATA_W'($urandom_range(0, 300));
                reg_vals[REG_SIGNAL_COUNT] = CFG_DATA_W'($urandom_range(0, 6));
                reg_vals[REG_SIGNAL_LEN]   = CFG_DATA_W'($urandom_range(0, 12));
            end
        endcase
    endtask

    // Eye signals mostly hold or jump; small wander and rail values fill in the rest.
    function automatic logic [11:0] next_level(input logic [11:0] cur);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40)
            return cur;
        if (r < 80)
            return 12'($urandom_range(0, 4095));
        if (r < 92)
        begin
            v = int'(cur) + int'($urandom_range(0, 60)) - 30;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            return 12'(v);
        end
        return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
    endfunction

    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return ACT_TICK;
        if (r < 93)
            return ACT_SNOOZE;
        if (r < 97)
            return ACT_RESTART;
        return ACT_SPARE;
    endfunction

    initial
    begin
        int p;
        int k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        stall_mode <= 0;
        @(posedge clk);

        // Register defaults: the window is far off, so only the buttons matter here.
        push_tick(ACT_TICK, 12'h000, 12'h000);
        push_tick(ACT_TICK, 12'hFFF, 12'hFFF);
        push_tick(ACT_RESTART, 12'h000, 12'h000);
        push_tick(ACT_RESTART, 12'hFFF, 12'h000);
        push_tick(ACT_SNOOZE, 12'hFFF, 12'h000);
        push_tick(ACT_SPARE, 12'd2048, 12'd2047);
        push_tick(ACT_RESTART, 12'd4080, 12'h000);
        push_tick(ACT_RESTART, 12'd4081, 12'h000);

        // Immediate detection with a REM call on every pass and a one-signal alert.
        drain();
        reg_vals[REG_SENSITIVITY]  = 22'd45;
        reg_vals[REG_TRIGGER]      = '0;
        reg_vals[REG_DECAY_PERIOD] = 22'd3;
        reg_vals[REG_INIT_DELAY]   = '0;
        reg_vals[REG_SNOOZE]       = '0;
        reg_vals[REG_POST_DELAY]   = '0;
        reg_vals[REG_SIGNAL_COUNT] = 22'd1;
        reg_vals[REG_SIGNAL_LEN]   = 22'd1;
        write_regs();
        push_tick(ACT_RESTART, 12'd4081, 12'h000);
        push_tick(ACT_TICK, 12'd4036, 12'd45);
        push_tick(ACT_TICK, 12'd3992, 12'd89);
        push_tick(ACT_TICK, 12'h000, 12'hFFF);
        push_tick(ACT_SNOOZE, 12'hFFF, 12'h000);
        push_tick(ACT_TICK, 12'h000, 12'hFFF);
        push_tick(ACT_TICK, 12'hFFF, 12'h000);
        push_tick(ACT_TICK, 12'hAAA, 12'h555);

        // Zero signal count, zero trigger and decay on every tick.
        drain();
        pick_config(CFG_FLOOR);
        write_regs();
        push_tick(ACT_RESTART, 12'h555, 12'hAAA);
        push_tick(ACT_TICK, 12'h555, 12'hAAA);
        push_tick(ACT_TICK, 12'hFFF, 12'h000);
        push_tick(ACT_SNOOZE, 12'h000, 12'hFFF);
        push_tick(ACT_TICK, 12'h001, 12'hFFE);

        for (p = 0; p < PHASES; p++)
        begin
            drain();
            pick_config((p == 0) ? CFG_FLOOR : (p == 1) ? CFG_CEIL : CFG_RANDOM);
            write_regs();
            stall_mode <= p % 3;
            gaps_on = (p % 2 == 0);
            burst_left = $urandom_range(0, 30);
            for (k = 0; k < PHASE_TICKS; k++)
            begin
                left_level = next_level(left_level);
                right_level = next_level(right_level);
                push_tick(pick_action(), left_level, right_level);
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (10) @(posedge clk);

        $display("%0d ticks under %0d register settings, %0d results compared",
                 ticks_sent, settings, results_seen);
        $display("%0d results with the alert running, %0d baseline captures on restart",
                 alert_ticks, baseline_captures);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
rtl/eyerem_pkg.sv
rtl/eye_motion_rem_detector_top.sv
sim/eyerem_tick_checker.sv
sim/tb_eye_motion_rem_detector_top.sv
